[rtl/mavw_pkg.sv]
package mavw_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int WINDOW_MAX    = 256;
   localparam int ADDR_BITS     = $clog2(WINDOW_MAX);
   localparam int LEN_BITS      = 9;
   localparam int SUM_BITS      = 24;
   localparam int MEAN_BITS     = 24;
   localparam int FRAC_BITS     = 8;
   localparam int DIVIDEND_BITS = SUM_BITS + FRAC_BITS;
   localparam int STEP_BITS     = $clog2(DIVIDEND_BITS);

   localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(8);
   localparam logic [LEN_BITS-1:0] LEN_MAX   = LEN_BITS'(WINDOW_MAX);

   // start request to the serial divider
   typedef struct packed {
      logic                  start;
      logic [SUM_BITS-1:0]   magnitude;
      logic [LEN_BITS-1:0]   divisor;
   } div_req_type;

   // divider status back to the control
   typedef struct packed {
      logic                  done;
      logic [MEAN_BITS-1:0]  quotient;
   } div_rsp_type;

endpackage

[rtl/mavw_ring.sv]
module mavw_ring
   import mavw_pkg::*;
(
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [ADDR_BITS-1:0]   wr_addr,
   input  logic [SAMPLE_BITS-1:0] wr_data,
   input  logic                   rd_en,
   input  logic [ADDR_BITS-1:0]   rd_addr,
   output logic [SAMPLE_BITS-1:0] rd_data
);

   logic [SAMPLE_BITS-1:0] mem_ff [WINDOW_MAX];
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/mavw_div.sv]
module mavw_div
   import mavw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;
   logic [DIVIDEND_BITS-1:0] dividend_ff, dividend_in;
   logic [LEN_BITS-1:0]      divisor_ff, divisor_in;
   logic [LEN_BITS-1:0]      rem_ff, rem_in;
   logic [MEAN_BITS-1:0]     quot_ff, quot_in;
   logic [LEN_BITS:0]        trial;
   logic                     fits;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial       = {rem_ff, dividend_ff[DIVIDEND_BITS-1]};
      fits        = trial >= {1'b0, divisor_ff};
      busy_in     = busy_ff;
      done_in     = 1'b0;
      step_in     = step_ff;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      quot_in     = quot_ff;
      if (div_req.start) begin
         busy_in     = 1'b1;
         step_in     = '0;
         dividend_in = {div_req.magnitude, {FRAC_BITS{1'b0}}};
         divisor_in  = div_req.divisor;
         rem_in      = '0;
         quot_in     = '0;
      end else if (busy_ff) begin
         rem_in      = fits ? LEN_BITS'(trial - {1'b0, divisor_ff}) : trial[LEN_BITS-1:0];
         quot_in     = {quot_ff[MEAN_BITS-2:0], fits};
         dividend_in = {dividend_ff[DIVIDEND_BITS-2:0], 1'b0};
         step_in     = step_ff + STEP_BITS'(1);
         if (step_ff == STEP_BITS'(DIVIDEND_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

[rtl/moving_average_window_core.sv]
// channel  | ports                                    | direction
// req      | req_valid, req_stall, req_sample         | sample in
// rsp      | rsp_valid, rsp_stall, rsp_valid_res,     | result out
//          | rsp_mean_q8                              |
// csr      | csr_valid, csr_ready, csr_window_length  | window length write
//
// one sample in flight at a time: each sample passes through the update, divide and output states,
// with the divide state spent in the bit-serial divider (one quotient bit per cycle)
// results before the window fills skip the divider
// synchronous reset clears control state and sets the window length to 8
// a stalled result holds in the output register; the next sample is taken
// meanwhile and waits in its last step until the output register frees up
module moving_average_window_core
   import mavw_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   // sample input
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   // result output
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_valid_res,
   output logic signed [MEAN_BITS-1:0]  rsp_mean_q8,
   // window length register
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [LEN_BITS-1:0]          csr_window_length
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_UPDATE,
      S_DIVIDE,
      S_OUTPUT
   } state_type;

   state_type                 state_ff, state_in;
   logic [LEN_BITS-1:0]       wlen_ff, wlen_in;
   logic [ADDR_BITS-1:0]      windex_ff, windex_in;
   logic                      full_ff, full_in;
   logic signed [SUM_BITS-1:0] sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0]    sample_ff, sample_in;
   logic [ADDR_BITS-1:0]      slot_ff, slot_in;
   logic                      neg_ff, neg_in;
   logic                      res_valid_ff, res_valid_in;
   logic [MEAN_BITS-1:0]      res_mean_ff, res_mean_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_res_ff, rsp_res_in;
   logic [MEAN_BITS-1:0]      rsp_mean_ff, rsp_mean_in;

   logic [LEN_BITS-1:0]       len_eff;
   logic [ADDR_BITS-1:0]      slot;
   logic                      req_xfer;
   logic                      out_free;
   logic [SAMPLE_BITS-1:0]    old_sample;
   logic signed [SUM_BITS-1:0] drop;
   logic signed [SUM_BITS-1:0] sum_next;
   logic [LEN_BITS-1:0]       slot_inc;
   logic                      wraps;
   logic                      ring_wr;
   div_req_type               div_req;
   div_rsp_type               div_rsp;

   // zero means one, anything past the ring size saturates
   always_comb begin
      if (wlen_ff == '0) begin
         len_eff = LEN_BITS'(1);
      end else if (wlen_ff > LEN_MAX) begin
         len_eff = LEN_MAX;
      end else begin
         len_eff = wlen_ff;
      end
   end

   // a write index left over from a longer window restarts at entry zero
   assign slot      = ({1'b0, windex_ff} >= len_eff) ? '0 : windex_ff;
   assign req_stall = state_ff != S_IDLE;
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // oldest sample drops out only once the ring has filled
   assign drop     = full_ff ? SUM_BITS'(signed'(old_sample)) : '0;
   assign sum_next = sum_ff + SUM_BITS'(signed'(sample_ff)) - drop;
   assign slot_inc = {1'b0, slot_ff} + LEN_BITS'(1);
   assign wraps    = slot_inc == len_eff;
   assign ring_wr  = state_ff == S_UPDATE;

   always_comb begin
      state_in     = state_ff;
      wlen_in      = wlen_ff;
      windex_in    = windex_ff;
      full_in      = full_ff;
      sum_in       = sum_ff;
      sample_in    = sample_ff;
      slot_in      = slot_ff;
      neg_in       = neg_ff;
      res_valid_in = res_valid_ff;
      res_mean_in  = res_mean_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_res_in   = rsp_res_ff;
      rsp_mean_in  = rsp_mean_ff;
      div_req      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               sample_in = req_sample;
               slot_in   = slot;
               state_in  = S_UPDATE;
            end
         end
         S_UPDATE: begin
            // ring read data for the slot arrived this cycle
            sum_in = sum_next;
            if (wraps) begin
               windex_in = '0;
               full_in   = 1'b1;
            end else begin
               windex_in = slot_inc[ADDR_BITS-1:0];
            end
            if (full_ff || wraps) begin
               neg_in            = sum_next[SUM_BITS-1];
               div_req.start     = 1'b1;
               div_req.magnitude = sum_next[SUM_BITS-1] ? SUM_BITS'(-sum_next)
                                                        : SUM_BITS'(sum_next);
               div_req.divisor   = len_eff;
               state_in          = S_DIVIDE;
            end else begin
               // window still filling: nil result
               res_valid_in = 1'b0;
               res_mean_in  = '0;
               state_in     = S_OUTPUT;
            end
         end
         S_DIVIDE: begin
            if (div_rsp.done) begin
               res_valid_in = 1'b1;
               res_mean_in  = neg_ff ? MEAN_BITS'(-div_rsp.quotient) : div_rsp.quotient;
               state_in     = S_OUTPUT;
            end
         end
         S_OUTPUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = res_valid_ff;
               rsp_mean_in  = res_mean_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a length write restarts filling
      if (csr_valid && csr_ready) begin
         wlen_in   = csr_window_length;
         windex_in = '0;
         full_in   = 1'b0;
         sum_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wlen_ff      <= LEN_RESET;
         windex_ff    <= '0;
         full_ff      <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wlen_ff      <= wlen_in;
         windex_ff    <= windex_in;
         full_ff      <= full_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff    <= sample_in;
      slot_ff      <= slot_in;
      neg_ff       <= neg_in;
      res_valid_ff <= res_valid_in;
      res_mean_ff  <= res_mean_in;
      rsp_res_ff   <= rsp_res_in;
      rsp_mean_ff  <= rsp_mean_in;
   end

   // sample ring: read the slot at the input transfer, overwrite it in the cycle after
   mavw_ring u_ring (
      .clock   (clock),
      .wr_en   (ring_wr),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_en   (req_xfer),
      .rd_addr (slot),
      .rd_data (old_sample)
   );

   // sum * 256 / length, one quotient bit per cycle
   mavw_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_res_ff;
   assign rsp_mean_q8   = signed'(rsp_mean_ff);

endmodule

[rtl/mavw_checker.sv]
module mavw_checker
   import mavw_pkg::*;
(
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_valid_res,
   input logic signed [MEAN_BITS-1:0]   rsp_mean_q8
);

   // nothing pending right after reset, input open
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or stall left over after reset");

   // one sample at a time: busy right after a transfer in
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second sample taken while one is in flight");

   // a nil result carries a zero mean
   a_nil_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_mean_q8 == '0)
      else $error("nil result with nonzero mean");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_valid_res) && $stable(rsp_mean_q8))
      else $error("stalled result changed");

endmodule

bind moving_average_window_core mavw_checker u_mavw_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_valid_res     (rsp_valid_res),
   .rsp_mean_q8       (rsp_mean_q8)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top
   import mavw_pkg::*;
();

   // one expected result: valid flag and Q8 mean
   typedef struct packed {
      logic                        ok;
      logic signed [MEAN_BITS-1:0] mean;
   } mean_result_type;

   // running-sum model of the averaging window plus the queue of expected results
   class mean_scoreboard;
      logic signed [SAMPLE_BITS-1:0] ring [WINDOW_MAX];
      int unsigned                   wr_idx;
      bit                            full;
      longint                        run_sum;
      logic [LEN_BITS-1:0]           len_reg;
      mean_result_type               expected_q [$];
      int                            errors;
      int                            checked;
      int                            valid_count;

      function new();
         foreach (ring[i]) ring[i] = '0;
         len_reg     = LEN_RESET;
         errors      = 0;
         checked     = 0;
         valid_count = 0;
         restart();
      endfunction

      function void restart();
         wr_idx  = 0;
         full    = 1'b0;
         run_sum = 0;
      endfunction

      function void set_length(logic [LEN_BITS-1:0] value);
         len_reg = value;
         restart();
      endfunction

      // zero reads as one, anything above the ring size saturates
      function int unsigned window_size();
         if (len_reg == '0)
            return 1;
         if (len_reg > LEN_MAX)
            return WINDOW_MAX;
         return 32'(len_reg);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_sample(logic signed [SAMPLE_BITS-1:0] x);
         int unsigned     n;
         int unsigned     idx;
         longint          scaled;
         mean_result_type res;
         n   = window_size();
         idx = wr_idx;
         if (idx >= n)
            idx = 0;
         if (full)
            run_sum -= ring[idx];
         ring[idx] = x;
         run_sum  += x;
         idx++;
         if (idx == n) begin
            full = 1'b1;
            idx  = 0;
         end
         wr_idx = idx;
         if (!full) begin
            res.ok   = 1'b0;
            res.mean = '0;
         end else begin
            // signed division truncates toward zero
            scaled   = (run_sum * 256) / longint'(n);
            res.ok   = 1'b1;
            res.mean = scaled[MEAN_BITS-1:0];
         end
         expected_q.push_back(res);
      endfunction

      function void check_result(logic ok, logic signed [MEAN_BITS-1:0] mean);
         mean_result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: result transfer with nothing pending: valid=%0b mean=%0d",
                     $time, ok, mean);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (ok)
            valid_count++;
         if (ok !== want.ok) begin
            $display("%0t: valid_res mismatch: expected %0b, actual %0b", $time, want.ok, ok);
            errors++;
         end
         if (mean !== want.mean) begin
            $display("%0t: mean_q8 mismatch: expected %0d, actual %0d",
                     $time, want.mean, mean);
            errors++;
         end
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic                          rsp_valid_res;
   logic signed [MEAN_BITS-1:0]   rsp_mean_q8;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [LEN_BITS-1:0]           csr_window_length;

   mean_scoreboard sb;
   int             burst_left;
   int             items_sent;
   int             settings_done;
   bit             long_hold;

   moving_average_window_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_valid_res     (rsp_valid_res),
      .rsp_mean_q8       (rsp_mean_q8),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_window_length (csr_window_length)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // generous ceiling, far beyond the slowest legal run
   initial begin
      #15_000_000;
      $display("moving_average_window_core verification failed");
      $finish;
   end

   // result transfers are checked against the oldest pending expectation;
   // signals are read before this edge's updates land, so these are the sampled values
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_valid_res, rsp_mean_q8);
   end

   // receiver back-pressure: random runs of open, light, even and heavy stalling,
   // plus a long hold-off on request so the core fills and stalls its input
   initial begin
      int run;
      int mode;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         run  = $urandom_range(1, 60);
         repeat (run) begin
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= 1'($urandom_range(0, 1));
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // mostly full-range random, with a share of rail values and small values near zero
   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         1:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         2:       return SAMPLE_BITS'($urandom_range(0, 16) - 8);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // one sample transfer; called at a clock edge, returns at the edge that took it.
   // the sender works in bursts with random gaps between them
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
         burst_left = $urandom_range(1, 40);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid  <= 1'b1;
      req_sample <= x;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_sample(x);
      items_sent++;
   endtask

   // let every pending result come out so the core is idle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_window(input logic [LEN_BITS-1:0] len);
      csr_valid         <= 1'b1;
      csr_window_length <= len;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.set_length(len);
      settings_done++;
   endtask

   // new window length, then enough samples to fill it and slide past it
   task automatic run_phase(input logic [LEN_BITS-1:0] len, input bit with_hold);
      int count;
      drain();
      write_window(len);
      count = sb.window_size() + $urandom_range(10, 60);
      for (int i = 0; i < count; i++) begin
         if (with_hold && i == count / 2)
            long_hold = 1'b1;
         send_sample(pick_sample());
      end
   endtask

   initial begin
      logic [LEN_BITS-1:0] len_plan [$];
      sb                = new();
      burst_left        = 0;
      items_sent        = 0;
      settings_done     = 0;
      long_hold         = 1'b0;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_sample        <= '0;
      csr_valid         <= 1'b0;
      csr_window_length <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset window of 8: rails give the largest and smallest means,
      // then small values around zero for truncation toward zero
      for (int i = 0; i < 8; i++) send_sample({1'b0, {(SAMPLE_BITS-1){1'b1}}});
      for (int i = 0; i < 8; i++) send_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}});
      send_sample(SAMPLE_BITS'(-1));
      send_sample(SAMPLE_BITS'(1));
      send_sample(SAMPLE_BITS'(0));
      send_sample(SAMPLE_BITS'(-7));
      send_sample(SAMPLE_BITS'(5));

      // zero acts as one, all-ones saturates to the ring size, then assorted sizes
      len_plan = '{9'd0, 9'd1, 9'd2, 9'd511, 9'd256, 9'd3, 9'd7, 9'd100, 9'd255};
      foreach (len_plan[i])
         run_phase(len_plan[i], (i == 2) || (i == 7));
      while (items_sent < 1700)
         run_phase(LEN_BITS'($urandom_range(0, 511)), 1'b0);

      drain();
      repeat (40) @(posedge clock);
      $display("covered %0d sample transfers over %0d window settings after reset",
               items_sent, settings_done);
      $display("checked %0d results, %0d with a full window", sb.checked, sb.valid_count);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("moving_average_window_core verification clean");
      end else begin
         $display("moving_average_window_core verification failed");
      end
      $finish;
   end

endmodule
